// ===== rtl/core/fba_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame bitmap allocator package
// Shared sizes, request codes, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package fba_pkg;

    // Bitmap geometry
    localparam int NUM_FRAMES = 4096;
    localparam int WORD_BITS  = 32;
    localparam int WORDS      = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW    = $clog2(WORDS);
    localparam int BIT_AW     = $clog2(WORD_BITS);
    localparam int FRAME_W    = 12;
    localparam int CFG_W      = 13;
    // Word count holds 0 to WORDS inclusive
    localparam int WCNT_W     = WORD_AW + 1;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(NUM_FRAMES);
    localparam logic [CFG_W-1:0] CFG_LIMIT = CFG_W'(NUM_FRAMES);

    // Request codes
    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_TEST  = 2'd2;

    // Configuration register indexes
    localparam logic REG_FRAMES_IN_USE = 1'b0;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_RMW
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;          // capture the request fields
        logic scan_init;     // restart the word scan at word zero
        logic scan_run;      // issue the next scan read
        logic rd_req;        // read the word holding the requested frame
        logic rmw_commit;    // finish a free or test on the read word
        logic alloc_commit;  // mark the found frame and report it
        logic res_simple;    // report a request that needs no bitmap access
        logic res_full;      // report an allocate with no free frame
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_alloc_new;  // allocate for an entry with no frame
        logic is_rmw;        // free of a real frame, or test
        logic hit;           // checked word has a free frame
        logic exhaust;       // every scanned word is full
    } t_dp_stat;

endpackage

// ===== rtl/core/fba_ctrl.sv =====
// ----------------------------------------------------------------------------
// Frame bitmap allocator controller
// Sequences one request at a time: capture, dispatch, word scan or
// read-modify-write, then report.
// ----------------------------------------------------------------------------
module fba_ctrl
    import fba_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.is_alloc_new) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end else if (i_stat.is_rmw) begin
                    o_cmd.rd_req = 1'b1;
                    n_state      = S_RMW;
                end else begin
                    o_cmd.res_simple = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    o_cmd.alloc_commit = 1'b1;
                    n_state            = S_IDLE;
                end else if (i_stat.exhaust) begin
                    o_cmd.res_full = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.scan_run = 1'b1;
                end
            end
            S_RMW: begin
                o_cmd.rmw_commit = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

`ifndef SYNTH
    // An accepted request always moves on to dispatch.
    a_start_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> (r_state == S_DISPATCH))
        else $error("accepted request did not reach dispatch");

    // Exactly one ending command leaves the scan.
    a_scan_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && n_state == S_IDLE) |->
            (o_cmd.alloc_commit != o_cmd.res_full))
        else $error("scan left without a single result");

    // Reading and writing the bitmap are never commanded together.
    a_no_commit_with_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.alloc_commit || o_cmd.rmw_commit) |-> !(o_cmd.rd_req || o_cmd.scan_run))
        else $error("bitmap read issued in a commit cycle");
`endif

endmodule

// ===== rtl/core/fba_datapath.sv =====
// ----------------------------------------------------------------------------
// Frame bitmap allocator datapath
// Holds the request, the bitmap memory with its per-word valid bits, the
// scan pipeline, the free-bit search and the result register.
// ----------------------------------------------------------------------------
module fba_datapath
    import fba_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic [CFG_W-1:0]   i_frames_in_use,
    input  logic [1:0]         i_mode,
    input  logic [FRAME_W-1:0] i_frame_index,
    input  logic               i_kernel_page,
    input  logic               i_rw_page,
    output logic               o_valid,
    output logic [FRAME_W-1:0] o_frame,
    output logic               o_present,
    output logic               o_writeable,
    output logic               o_user,
    output logic               o_full_res,
    output logic               o_in_use,
    output logic               o_changed
);

    // Captured request
    logic [1:0]         r_mode;
    logic [FRAME_W-1:0] r_fidx;
    logic               r_kern;
    logic               r_wr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_fidx <= i_frame_index;
            r_kern <= i_kernel_page;
            r_wr   <= i_rw_page;
        end
    end

    // Number of whole words to scan, with the limit saturated
    logic [CFG_W-1:0]  lim;
    logic [WCNT_W-1:0] num_words;

    assign lim       = (i_frames_in_use > CFG_LIMIT) ? CFG_LIMIT : i_frames_in_use;
    assign num_words = WCNT_W'(lim >> BIT_AW);

    // Scan address and the address of the word now in the read register
    logic [WCNT_W-1:0]  r_scan_addr;
    logic [WORD_AW-1:0] r_chk_addr;
    logic               r_chk_vld;
    logic               rd_en;
    logic [WORD_AW-1:0] rd_addr;
    logic               scan_rd;

    assign scan_rd = i_cmd.scan_run && (r_scan_addr < num_words);
    assign rd_en   = i_cmd.rd_req || scan_rd;
    assign rd_addr = i_cmd.rd_req ? r_fidx[FRAME_W-1:BIT_AW] : r_scan_addr[WORD_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_addr <= '0;
            r_chk_vld   <= 1'b0;
        end else begin
            if (i_cmd.scan_init) begin
                r_scan_addr <= '0;
                r_chk_vld   <= 1'b0;
            end else begin
                if (scan_rd) begin
                    r_scan_addr <= r_scan_addr + WCNT_W'(1);
                end
                r_chk_vld <= scan_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_chk_addr <= rd_addr;
        end
    end

    // Bitmap memory; a word never written since reset reads as all free
    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORD_BITS-1:0] r_rdata;
    logic [WORDS-1:0]     r_valid;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_chk_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[r_chk_addr] <= 1'b1;
        end
    end

    logic [WORD_BITS-1:0] word;
    assign word = r_valid[r_chk_addr] ? r_rdata : '0;

    // Lowest clear bit of the checked word
    logic [BIT_AW-1:0] free_bit;
    always_comb begin
        free_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!word[i]) begin
                free_bit = BIT_AW'(i);
            end
        end
    end

    // Bit of the requested frame within the checked word
    logic [WORD_BITS-1:0] free_mask;
    logic [WORD_BITS-1:0] req_mask;
    logic                 req_bit;

    assign free_mask = WORD_BITS'(1) << free_bit;
    assign req_mask  = WORD_BITS'(1) << r_fidx[BIT_AW-1:0];
    assign req_bit   = word[r_fidx[BIT_AW-1:0]];

    // Write back for a successful allocate or a free
    assign wr_en   = i_cmd.alloc_commit || (i_cmd.rmw_commit && r_mode == MODE_FREE);
    assign wr_data = i_cmd.alloc_commit ? (word | free_mask) : (word & ~req_mask);

    // Status for the controller
    assign o_stat.is_alloc_new = (r_mode == MODE_ALLOC) && (r_fidx == '0);
    assign o_stat.is_rmw       = (r_mode == MODE_TEST) ||
                                 ((r_mode == MODE_FREE) && (r_fidx != '0));
    assign o_stat.hit          = r_chk_vld && !(&word);
    assign o_stat.exhaust      = !r_chk_vld && (r_scan_addr >= num_words);

    // Result register
    logic               r_o_valid;
    logic [FRAME_W-1:0] r_o_frame;
    logic               r_o_present;
    logic               r_o_writeable;
    logic               r_o_user;
    logic               r_o_full;
    logic               r_o_in_use;
    logic               r_o_changed;
    logic               res_any;

    assign res_any = i_cmd.res_simple || i_cmd.res_full ||
                     i_cmd.alloc_commit || i_cmd.rmw_commit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= res_any;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_any) begin
            r_o_frame     <= '0;
            r_o_present   <= 1'b0;
            r_o_writeable <= 1'b0;
            r_o_user      <= 1'b0;
            r_o_full      <= 1'b0;
            r_o_in_use    <= 1'b0;
            r_o_changed   <= 1'b0;
            if (i_cmd.alloc_commit) begin
                r_o_frame     <= {r_chk_addr, free_bit};
                r_o_present   <= 1'b1;
                r_o_writeable <= r_wr;
                r_o_user      <= !r_kern;
                r_o_changed   <= 1'b1;
            end else if (i_cmd.res_full) begin
                r_o_full <= 1'b1;
            end else if (i_cmd.rmw_commit) begin
                if (r_mode == MODE_TEST) begin
                    r_o_frame  <= r_fidx;
                    r_o_in_use <= req_bit;
                end else begin
                    r_o_changed <= req_bit;
                end
            end else if (r_mode == MODE_ALLOC) begin
                // Entry already holds a frame: echo it untouched
                r_o_frame <= r_fidx;
            end
        end
    end

    assign o_valid     = r_o_valid;
    assign o_frame     = r_o_frame;
    assign o_present   = r_o_present;
    assign o_writeable = r_o_writeable;
    assign o_user      = r_o_user;
    assign o_full_res  = r_o_full;
    assign o_in_use    = r_o_in_use;
    assign o_changed   = r_o_changed;

`ifndef SYNTH
    // Result strobes never come back to back.
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |=> !r_o_valid)
        else $error("back-to-back result strobes");

    // A granted frame always changes the bitmap and is never full.
    a_grant_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_present) |-> (r_o_changed && !r_o_full))
        else $error("inconsistent allocate result flags");

    // The word holding a granted frame is valid afterwards.
    a_grant_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc_commit |=> r_valid[$past(r_chk_addr)])
        else $error("allocated word not marked valid");

    // A full result carries no frame.
    a_full_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_full) |-> (r_o_frame == '0 && !r_o_present))
        else $error("full result carries a frame");
`endif

endmodule

// ===== rtl/core/frame_bitmap_allocator.sv =====
// Requests that need no bitmap access report straight from dispatch, free and
// test after a read of the requested word, and allocate after a word scan of
// at most 128 words, reporting full when no scanned word has a free frame.
// One request is in flight at a time; busy is high until its result strobes.
// Reset is synchronous: the bitmap reads as all free at once via per-word
// valid bits, and frames_in_use returns to 4096. The receiver cannot stall.
// ----------------------------------------------------------------------------
// Frame bitmap allocator
// First-fit page-frame allocator over a bitmap of used frames, with an APB
// register for the number of managed frames.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator
    import fba_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Request channel
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_mode,
    input  logic [FRAME_W-1:0] i_frame_index,
    input  logic               i_kernel_page,
    input  logic               i_rw_page,
    // Result channel
    output logic               o_valid,
    output logic [FRAME_W-1:0] o_frame,
    output logic               o_present,
    output logic               o_writeable,
    output logic               o_user,
    output logic               o_full_res,
    output logic               o_in_use,
    output logic               o_changed,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Configuration register
    logic [CFG_W-1:0] r_frames_in_use;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_FRAMES_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= CFG_RESET;
        end else if (cfg_wr) begin
            r_frames_in_use <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_FRAMES_IN_USE) ? {{(32-CFG_W){1'b0}}, r_frames_in_use}
                                                    : 32'd0;

    // Controller
    fba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Datapath
    fba_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_frames_in_use (r_frames_in_use),
        .i_mode          (i_mode),
        .i_frame_index   (i_frame_index),
        .i_kernel_page   (i_kernel_page),
        .i_rw_page       (i_rw_page),
        .o_valid         (o_valid),
        .o_frame         (o_frame),
        .o_present       (o_present),
        .o_writeable     (o_writeable),
        .o_user          (o_user),
        .o_full_res      (o_full_res),
        .o_in_use        (o_in_use),
        .o_changed       (o_changed)
    );

endmodule
